/* rtl/cmlfb_pkg.sv */
// Shared types, codes and helpers for the colour memory LCD frame buffer.
`timescale 1ns / 1ps

package cmlfb_pkg;

  // Operation codes carried in the input tuser field
  typedef enum logic [1:0] {
    OP_SET_PIXEL  = 2'd0,
    OP_FILL_ROW   = 2'd1,
    OP_EMIT_ROW   = 2'd2,
    OP_EMIT_CLEAR = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic CFG_UPDATE_COMMAND = 1'b0;
  localparam logic CFG_CLEAR_COMMAND  = 1'b1;

  // Register reset values
  localparam logic [7:0] UPDATE_COMMAND_RST = 8'h01;
  localparam logic [7:0] CLEAR_COMMAND_RST  = 8'h04;

  // Bit order swap, the panel shifts MSB first
  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

endpackage

/* rtl/cmlfb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module cmlfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/color_memory_lcd_frame_buffer.sv */
// Top level: colour memory LCD frame buffer with row and clear frame generator.
//
//  Channel   Dir  Handshake            Content
//  s_axis    in   tvalid/tready        tuser: op; tdata: row, column, colour
//  m_axis    out  tvalid/tready        tdata: out_byte; tlast: frame_end
//  cfg       in   cfg_we_i (no wait)   cfg_index_i selects register, cfg_data_i
//
// After reset a clearing pass writes 0xFF to every buffer byte, one byte a
// cycle (ROWS*BYTES_PER_ROW bytes, 6144 by default); no input is taken then.
// Set pixel does a read-modify-write of one or two bytes over the single
// RAM write port. Fill row reads and writes back the row, one byte read and
// one written per cycle. Emit row gives BYTES_PER_ROW+4 bytes at one
// per cycle, emit clear gives 2; a stalled output holds the sequencer.
// Input is taken only while the sequencer is idle.
`timescale 1ns / 1ps

module color_memory_lcd_frame_buffer #(
  parameter int ROWS          = 128,
  parameter int COLUMNS       = 128,
  parameter int BYTES_PER_ROW = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input transactions
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // row [6:0], column [13:7], colour [16:14], zero pad
  input  logic [1:0]  s_axis_tuser_i,  // op [1:0]
  // output transactions
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_byte [7:0]
  output logic        m_axis_tlast_o,  // frame_end
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int DEPTH     = ROWS * BYTES_PER_ROW;
  localparam int AW        = $clog2(DEPTH);
  localparam int IW        = $clog2(BYTES_PER_ROW + 4);
  localparam int CW        = $clog2(COLUMNS);
  localparam int PBW       = $clog2(3 * COLUMNS);
  localparam int SBW       = PBW - 3;
  localparam int FILL_BITS = 3 * COLUMNS;
  localparam int GW_A      = IW + 3;
  localparam int GW_B      = $clog2(FILL_BITS + 1);
  localparam int GW        = (GW_A > GW_B) ? GW_A : GW_B;

  // Sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SP_RD  = 3'd2;
  localparam logic [2:0] ST_SP_WR0 = 3'd3;
  localparam logic [2:0] ST_SP_WR1 = 3'd4;
  localparam logic [2:0] ST_FILL   = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0]     state_q, state_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic [IW-1:0]  wr_idx_q, wr_idx_d;
  logic           wr_pend_q, wr_pend_d;
  logic [1:0]     phase_q, phase_d;
  logic [7:0]     update_cmd_q, clear_cmd_q;
  logic           out_valid_q, out_valid_d;
  logic           out_load;
  logic [7:0]     out_byte_q, out_byte_d;
  logic           out_last_q, out_last_d;

  // Operation payload latched at accept
  logic [6:0]     row_q;
  logic [2:0]     colour_q;
  logic [SBW-1:0] sp_byte_q;
  logic [2:0]     sp_off_q;
  logic [AW-1:0]  row_base_q;
  logic           mode_clear_q;

  // RAM port signals
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  // Input field decode
  logic [6:0]        in_row;
  logic [6:0]        in_column;
  logic [2:0]        in_colour;
  cmlfb_pkg::op_e    in_op;
  logic              in_accept;
  logic              row_ok, col_ok;
  logic [CW-1:0]     mirror;
  logic [PBW-1:0]    base_bit;
  logic [AW-1:0]     in_row_base;

  assign in_row    = s_axis_tdata_i[6:0];
  assign in_column = s_axis_tdata_i[13:7];
  assign in_colour = s_axis_tdata_i[16:14];
  assign in_op     = cmlfb_pkg::op_e'(s_axis_tuser_i);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;

  assign row_ok      = {2'b00, in_row} < 9'(ROWS);
  assign col_ok      = {2'b00, in_column} < 9'(COLUMNS);
  assign mirror      = CW'(COLUMNS - 1) - CW'(in_column);
  assign base_bit    = PBW'(32'(mirror) * 3);
  assign in_row_base = AW'(32'(in_row) * BYTES_PER_ROW);

  // Set pixel window: three colour bits at the bit offset, across two bytes
  logic [15:0] sp_win, sp_mask;
  logic        sp_lo_ok, sp_hi_ok;

  assign sp_win   = {13'd0, colour_q} << sp_off_q;
  assign sp_mask  = 16'h0007 << sp_off_q;
  assign sp_lo_ok = 32'(sp_byte_q) < BYTES_PER_ROW;
  assign sp_hi_ok = (32'(sp_byte_q) + 1) < BYTES_PER_ROW;

  // Fill row byte: colour repeated with the byte's phase, bits past the
  // last pixel keep their stored value
  function automatic logic [7:0] fill_pattern(input logic [2:0] colour,
                                              input logic [1:0] phase);
    logic [7:0] pat;
    logic [1:0] p;
    p = phase;
    for (int k = 0; k < 8; k++) begin
      pat[k] = colour[p];
      p      = (p == 2'd2) ? 2'd0 : p + 2'd1;
    end
    return pat;
  endfunction

  logic [7:0] fill_in_row;
  logic [7:0] fill_byte;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      fill_in_row[k] = GW'({wr_idx_q, 3'(k)}) < GW'(FILL_BITS);
    end
  end

  assign fill_byte = (ram_rdata & ~fill_in_row)
                   | (fill_pattern(colour_q, phase_q) & fill_in_row);

  // Output byte for the current frame position
  logic [7:0] emit_byte;
  logic       emit_last;

  always_comb begin
    emit_byte = 8'h00;
    emit_last = 1'b0;
    if (mode_clear_q) begin
      if (idx_q == '0) begin
        emit_byte = clear_cmd_q;
      end
      emit_last = (idx_q == IW'(1));
    end else begin
      if (idx_q == '0) begin
        emit_byte = update_cmd_q;
      end else if (idx_q == IW'(1)) begin
        emit_byte = cmlfb_pkg::rev8(8'(ROWS - 1) - {1'b0, row_q});
      end else if (idx_q <= IW'(BYTES_PER_ROW + 1)) begin
        emit_byte = cmlfb_pkg::rev8(ram_rdata);
      end
      emit_last = (idx_q == IW'(BYTES_PER_ROW + 3));
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    wr_idx_d    = wr_idx_q;
    wr_pend_d   = wr_pend_q;
    phase_d     = phase_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_load    = 1'b0;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 8'hFF;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          idx_d     = '0;
          wr_idx_d  = '0;
          wr_pend_d = 1'b0;
          phase_d   = 2'd0;
          unique case (in_op)
            cmlfb_pkg::OP_SET_PIXEL: begin
              if (row_ok && col_ok) begin
                state_d = ST_SP_RD;
              end
            end
            cmlfb_pkg::OP_FILL_ROW: begin
              if (row_ok) begin
                state_d = ST_FILL;
              end
            end
            cmlfb_pkg::OP_EMIT_ROW: begin
              if (row_ok) begin
                state_d = ST_EMIT;
              end
            end
            cmlfb_pkg::OP_EMIT_CLEAR: begin
              state_d = ST_EMIT;
            end
          endcase
        end
      end

      ST_SP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = row_base_q + AW'(sp_byte_q);
        state_d   = ST_SP_WR0;
      end

      ST_SP_WR0: begin
        ram_we    = sp_lo_ok;
        ram_waddr = row_base_q + AW'(sp_byte_q);
        ram_wdata = (ram_rdata & ~sp_mask[7:0]) | (sp_win[7:0] & sp_mask[7:0]);
        if (sp_mask[15:8] != 8'h00) begin
          ram_re    = 1'b1;
          ram_raddr = row_base_q + AW'(sp_byte_q) + AW'(1);
          state_d   = ST_SP_WR1;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_SP_WR1: begin
        ram_we    = sp_hi_ok;
        ram_waddr = row_base_q + AW'(sp_byte_q) + AW'(1);
        ram_wdata = (ram_rdata & ~sp_mask[15:8]) | (sp_win[15:8] & sp_mask[15:8]);
        state_d   = ST_IDLE;
      end

      ST_FILL: begin
        // read byte idx while writing back the byte read last cycle
        if (wr_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = row_base_q + AW'(wr_idx_q);
          ram_wdata = fill_byte;
          phase_d   = (phase_q == 2'd0) ? 2'd2 : phase_q - 2'd1;
        end
        if (idx_q < IW'(BYTES_PER_ROW)) begin
          ram_re    = 1'b1;
          ram_raddr = row_base_q + AW'(idx_q);
          wr_idx_d  = idx_q;
          wr_pend_d = 1'b1;
          idx_d     = idx_q + IW'(1);
        end else begin
          wr_pend_d = 1'b0;
          if (!wr_pend_q) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_byte_d  = emit_byte;
          out_last_d  = emit_last;
          // prefetch data byte idx-1 so it is ready for the next position
          if (!mode_clear_q && idx_q != '0 && idx_q <= IW'(BYTES_PER_ROW)) begin
            ram_re    = 1'b1;
            ram_raddr = row_base_q + AW'(idx_q - IW'(1));
          end
          if (emit_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      idx_q        <= '0;
      wr_idx_q     <= '0;
      wr_pend_q    <= 1'b0;
      phase_q      <= 2'd0;
      out_valid_q  <= 1'b0;
      update_cmd_q <= cmlfb_pkg::UPDATE_COMMAND_RST;
      clear_cmd_q  <= cmlfb_pkg::CLEAR_COMMAND_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      idx_q       <= idx_d;
      wr_idx_q    <= wr_idx_d;
      wr_pend_q   <= wr_pend_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          cmlfb_pkg::CFG_UPDATE_COMMAND: update_cmd_q <= cfg_data_i;
          cmlfb_pkg::CFG_CLEAR_COMMAND:  clear_cmd_q  <= cfg_data_i;
          default:                       update_cmd_q <= update_cmd_q;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      row_q        <= in_row;
      colour_q     <= in_colour;
      sp_byte_q    <= base_bit[PBW-1:3];
      sp_off_q     <= base_bit[2:0];
      row_base_q   <= in_row_base;
      mode_clear_q <= (in_op == cmlfb_pkg::OP_EMIT_CLEAR);
    end
    if (out_load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

  // Frame buffer store
  cmlfb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule
